FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the base-relocation parser RTL.
// Compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion, ignored while reset is asserted.
`define BRTP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define BRTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRTP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/core/brtp_pkg.sv
// Types and constants of the base-relocation table parser.
// No dependencies; used by every other RTL file.
package brtp_pkg;

	localparam int WORD_W     = 16;
	localparam int ADDR_W     = 64;
	localparam int PAGE_W     = 32;
	localparam int BASE_W     = PAGE_W + 1;
	localparam int OFFSET_W   = 12;
	localparam int TYPE_W     = WORD_W - OFFSET_W;
	localparam int ENTRIES_W  = 31;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// header is page address plus block size: four words
	localparam int HDR_WORDS = 4;

	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic [TYPE_W-1:0] TYPE_ABS     = TYPE_W'(0);
	localparam logic [TYPE_W-1:0] TYPE_HIGHLOW = TYPE_W'(3);
	localparam logic [TYPE_W-1:0] TYPE_DIR64   = TYPE_W'(10);

	localparam logic [CFG_IDX_W-1:0] REG_LOAD_SLIDE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PTR64      = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		PH_PAGE_LO,
		PH_PAGE_HI,
		PH_SIZE_LO,
		PH_SIZE_HI,
		PH_ENTRY
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADDR     = 3'd0,
		KIND_END      = 3'd1,
		KIND_BAD_TYPE = 3'd2,
		KIND_NOT_ASC  = 3'd3,
		KIND_BAD_SIZE = 3'd4
	} kind_t;

	// command handed from the classifier to the address unit
	typedef struct packed {
		kind_t             kind;
		logic [BASE_W-1:0] base;   // page + offset, slide not yet added
	} cmd_t;

endpackage

FILE: rtl/core/brtp_ifs.sv
// Valid/ready channel interfaces of the base-relocation table parser.
// Depends on brtp_pkg.
interface brtp_word_if;
	import brtp_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] table_word;
	logic              final_word;

	modport source(output valid, output table_word, output final_word, input ready);
	modport sink(input valid, input table_word, input final_word, output ready);
endinterface

interface brtp_result_if;
	import brtp_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [ADDR_W-1:0] fixup_address;

	modport source(output valid, output result_kind, output fixup_address, input ready);
	modport sink(input valid, input result_kind, input fixup_address, output ready);
endinterface

FILE: rtl/core/brtp_front.sv
// Front end: takes table words, tracks the header/entry phase and
// classifies each word into a command for the address unit. Uses brtp_pkg.
module brtp_front (
	input  logic                clk,
	input  logic                arst_n,
	brtp_word_if.sink           words,
	input  logic                ptr64,
	input  logic                fifo_full,
	output logic                push,
	output brtp_pkg::cmd_t      cmd
);
	import brtp_pkg::*;

	phase_t                 phase_q, phase_d;
	logic                   halted_q;
	logic [WORD_W-1:0]      latch_q;
	logic [PAGE_W-1:0]      page_q;
	logic [ENTRIES_W-1:0]   entries_q;

	logic                   accept;
	logic                   live;
	logic                   stop;
	logic [ENTRIES_W-1:0]   size_words;
	logic [ENTRIES_W-1:0]   entries_dec;
	logic [TYPE_W-1:0]      etype;
	logic [TYPE_W-1:0]      ptr_type;
	logic [OFFSET_W-1:0]    offset;

	assign words.ready = !fifo_full;
	assign accept      = words.valid && words.ready;
	assign live        = accept && !halted_q;

	// size in bytes halved; low bit of the size is dropped
	assign size_words  = {words.table_word, latch_q[WORD_W-1:1]};
	assign entries_dec = (entries_q != '0) ? entries_q - ENTRIES_W'(1) : entries_q;
	assign etype       = words.table_word[WORD_W-1:OFFSET_W];
	assign offset      = words.table_word[OFFSET_W-1:0];
	assign ptr_type    = ptr64 ? TYPE_DIR64 : TYPE_HIGHLOW;

	// outputs: command and halt decision
	always_comb begin
		push     = 1'b0;
		stop     = 1'b0;
		cmd.kind = KIND_END;
		cmd.base = BASE_W'(page_q) + BASE_W'(offset);
		if (live) begin
			unique case (phase_q)
				PH_SIZE_HI: begin
					if (size_words == '0) begin
						push = 1'b1;
						stop = 1'b1;
					end else if (size_words < ENTRIES_W'(HDR_WORDS)) begin
						push     = 1'b1;
						stop     = 1'b1;
						cmd.kind = KIND_BAD_SIZE;
					end
				end
				PH_ENTRY: begin
					if (etype == TYPE_ABS) begin
						push = 1'b0;
					end else if (etype != ptr_type) begin
						push     = 1'b1;
						stop     = 1'b1;
						cmd.kind = KIND_BAD_TYPE;
					end else begin
						push     = 1'b1;
						cmd.kind = KIND_ADDR;
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
			// last word: end mark only if this word produced nothing
			if (words.final_word && !stop) begin
				stop = 1'b1;
				if (!push) begin
					push     = 1'b1;
					cmd.kind = KIND_END;
				end
			end
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (live) begin
			unique case (phase_q)
				PH_PAGE_LO: phase_d = PH_PAGE_HI;
				PH_PAGE_HI: phase_d = PH_SIZE_LO;
				PH_SIZE_LO: phase_d = PH_SIZE_HI;
				PH_SIZE_HI: begin
					if (size_words >= ENTRIES_W'(HDR_WORDS)) begin
						phase_d = (size_words != ENTRIES_W'(HDR_WORDS)) ? PH_ENTRY : PH_PAGE_LO;
					end
				end
				PH_ENTRY: begin
					if (entries_dec == '0) begin
						phase_d = PH_PAGE_LO;
					end
				end
				default: phase_d = PH_PAGE_LO;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PAGE_LO;
			halted_q  <= 1'b0;
			latch_q   <= '0;
			page_q    <= '0;
			entries_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (stop) begin
				halted_q <= 1'b1;
			end
			if (live) begin
				unique case (phase_q)
					PH_PAGE_LO: latch_q   <= words.table_word;
					PH_PAGE_HI: page_q    <= {words.table_word, latch_q};
					PH_SIZE_LO: latch_q   <= words.table_word;
					PH_SIZE_HI: entries_q <= size_words - ENTRIES_W'(HDR_WORDS);
					PH_ENTRY:   entries_q <= entries_dec;
					default:    latch_q   <= latch_q;
				endcase
			end
		end
	end

endmodule

FILE: rtl/core/brtp_fifo.sv
// Four-entry command queue between the classifier and the address unit.
// Depends on brtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module brtp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  brtp_pkg::cmd_t   wr_cmd,
	input  logic             pop,
	output brtp_pkg::cmd_t   rd_cmd,
	output logic             full,
	output logic             empty
);
	import brtp_pkg::*;

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full   = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

	`BRTP_ASSERT(a_no_overflow, clk, arst_n, push |-> !full, "push into full queue")
	`BRTP_ASSERT(a_no_underflow, clk, arst_n, pop |-> !empty, "pop from empty queue")
	`BRTP_ASSERT(a_count_range, clk, arst_n, count_q <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count out of range")

endmodule

FILE: rtl/core/brtp_back.sv
// Back end: adds the load slide, checks ascending order and holds the
// result register. Depends on brtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module brtp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [brtp_pkg::ADDR_W-1:0]   slide,
	input  logic                          cmd_valid,
	input  brtp_pkg::cmd_t                cmd,
	output logic                          pop,
	brtp_result_if.source                 results
);
	import brtp_pkg::*;

	logic              advance;
	logic              valid_s1;
	kind_t             kind_s1;
	logic [ADDR_W-1:0] sum_s1;

	logic              halted_q;
	logic [ADDR_W-1:0] prev_q;
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [ADDR_W-1:0] out_addr_q;

	logic              bad_order;
	logic              take;
	kind_t             emit_kind;
	logic [ADDR_W-1:0] emit_addr;

	assign advance = !out_valid_q || results.ready;
	assign pop     = advance && cmd_valid;
	assign take    = valid_s1 && !halted_q;

	// address must be strictly above the last one given out
	assign bad_order = (sum_s1 <= prev_q);

	always_comb begin
		emit_kind = kind_s1;
		emit_addr = '0;
		if (kind_s1 == KIND_ADDR) begin
			if (bad_order) begin
				emit_kind = KIND_NOT_ASC;
			end else begin
				emit_addr = sum_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= cmd.kind;
			sum_s1  <= slide + ADDR_W'(cmd.base);
		end
		if (advance) begin
			out_kind_q <= emit_kind;
			out_addr_q <= emit_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			halted_q    <= 1'b0;
			prev_q      <= '0;
		end else if (advance) begin
			valid_s1    <= cmd_valid;
			out_valid_q <= take;
			if (take) begin
				if (emit_kind == KIND_ADDR) begin
					prev_q <= sum_s1;
				end else begin
					halted_q <= 1'b1;
				end
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.result_kind   = out_kind_q;
	assign results.fixup_address = out_addr_q;

	`BRTP_ASSERT(a_quiet_after_halt, clk, arst_n, (halted_q && !out_valid_q) |=> !out_valid_q, "result after halt")
	`BRTP_ASSERT(a_zero_addr, clk, arst_n, (out_valid_q && out_kind_q != KIND_ADDR) |-> (out_addr_q == '0), "nonzero address on non-address result")
	`BRTP_ASSERT(a_prev_tracks, clk, arst_n, (out_valid_q && out_kind_q == KIND_ADDR) |-> (out_addr_q == prev_q), "last address not tracked")

endmodule

FILE: rtl/core/base_relocation_table_parser.sv
// Base-relocation table parser, top level.
// Input channel "words": one 16-bit table word per item plus a final-word flag.
// Output channel "results": result_kind (0 address, 1 end, 2 bad type,
// 3 not ascending, 4 bad size) and fixup_address (zero unless kind is 0).
// Words that give no result (header words, absolute entries) are consumed
// silently. A word's command passes through the command queue, the slide-add
// register and the result register. One word per cycle is taken as long as
// the four-entry queue has room, which it has while results.ready is high.
// When results.ready is low the result register holds, the queue fills, and
// words.ready drops once the queue is full.
// After an end mark or an error the block keeps accepting words and drops
// them until reset.
// Reset (arst_n low) returns the parser to the page-address phase, clears
// the order check, the queue and the halt, sets load_slide to 0 and
// pointer_is_64bit to 1. Configuration is written through cfg_we/cfg_index/
// cfg_data; index 0 is load_slide, 1 is pointer_is_64bit. The user must write
// it only while no item is in flight; the block does not enforce this.
// Depends on brtp_pkg, brtp_ifs, brtp_front, brtp_fifo, brtp_back.
module base_relocation_table_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	brtp_word_if.sink                         words,
	brtp_result_if.source                     results,
	input  logic                              cfg_we,
	input  logic [brtp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [brtp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import brtp_pkg::*;

	logic [ADDR_W-1:0] slide_q;
	logic              ptr64_q;

	logic fifo_full;
	logic fifo_empty;
	logic push;
	logic pop;
	cmd_t wr_cmd;
	cmd_t rd_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slide_q <= '0;
			ptr64_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOAD_SLIDE: slide_q <= cfg_data[ADDR_W-1:0];
				REG_PTR64:      ptr64_q <= cfg_data[0];
				default:        ptr64_q <= ptr64_q;
			endcase
		end
	end

	brtp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (words),
		.ptr64     (ptr64_q),
		.fifo_full (fifo_full),
		.push      (push),
		.cmd       (wr_cmd)
	);

	brtp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	brtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.slide     (slide_q),
		.cmd_valid (!fifo_empty),
		.cmd       (rd_cmd),
		.pop       (pop),
		.results   (results)
	);

endmodule

FILE: verif/tb_base_relocation_table_parser.sv
// Self-checking testbench for base_relocation_table_parser: streams relocation tables
// through the word channel under random gaps and stalls and compares each result item
// with an in-bench parser. Depends on brtp_pkg, brtp_ifs and the parser RTL.
module tb_base_relocation_table_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import brtp_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD   = 150;
	localparam int PHASE_WORDS = 430;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              fin;
	} tbl_word_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] addr;
	} fixup_t;

	typedef enum {STOP_FINAL, STOP_ZERO_SIZE, STOP_SHORT, STOP_BAD_TYPE, STOP_ORDER} stop_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_LOAD_SLIDE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	brtp_word_if   words();
	brtp_result_if results();

	base_relocation_table_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.words     (words),
		.results   (results),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tbl_word_t table_words[$];
	fixup_t    fixups_due[$];

	// parser state and register copies, at their reset values
	phase_t               ph           = PH_PAGE_LO;
	logic [PAGE_W-1:0]    page_base    = '0;
	logic [WORD_W-1:0]    low_latch    = '0;
	logic [ENTRIES_W-1:0] entries_left = '0;
	logic [ADDR_W-1:0]    last_fixup   = '0;
	logic                 halted       = 1'b0;
	logic [ADDR_W-1:0]    slide        = '0;
	logic                 ptr64        = 1'b1;

	// table generation
	logic [ADDR_W-1:0] gen_last = '0;
	logic [PAGE_W-1:0] page_cur = '0;
	int                queued   = 0;

	int        words_taken = 0;
	int        rx_taken    = 0;
	int        mismatches  = 0;
	int        tx_gap, rx_gap, rx_hold, stall_cycles = 0;
	bit        tx_burst    = 1'b0;
	bit        rx_burst    = 1'b0;
	tbl_word_t tx_next;
	fixup_t    rx_want;
	int        rx_draw;

	function automatic logic [TYPE_W-1:0] ptr_type_now();
		return ptr64 ? TYPE_DIR64 : TYPE_HIGHLOW;
	endfunction

	// advance the parser by one table word, queue the result item it causes
	function automatic void parse_word(input logic [WORD_W-1:0] w, input logic fin);
		logic [TYPE_W-1:0]   etype;
		logic [OFFSET_W-1:0] off;
		logic [31:0]         size;
		logic [ADDR_W-1:0]   a;
		fixup_t              r;
		bit                  hit;
		etype  = w[WORD_W-1:OFFSET_W];
		off    = w[OFFSET_W-1:0];
		hit    = 1'b0;
		r.kind = KIND_END;
		r.addr = '0;
		if (halted)
			return;
		case (ph)
		PH_PAGE_LO: begin
			low_latch = w;
			ph = PH_PAGE_HI;
		end
		PH_PAGE_HI: begin
			page_base = {w, low_latch};
			ph = PH_SIZE_LO;
		end
		PH_SIZE_LO: begin
			low_latch = w;
			ph = PH_SIZE_HI;
		end
		PH_SIZE_HI: begin
			size = {w, low_latch};
			if (size[31:1] == 0) begin
				hit = 1'b1;
				r.kind = KIND_END;
				halted = 1'b1;
			end else if (size[31:1] < HDR_WORDS) begin
				hit = 1'b1;
				r.kind = KIND_BAD_SIZE;
				halted = 1'b1;
			end else begin
				entries_left = ENTRIES_W'(size[31:1] - HDR_WORDS);
				ph = (entries_left != 0) ? PH_ENTRY : PH_PAGE_LO;
			end
		end
		default: begin
			if (entries_left != 0)
				entries_left = entries_left - 1'b1;
			if (entries_left == 0)
				ph = PH_PAGE_LO;
			if (etype == TYPE_ABS) begin
				hit = 1'b0;
			end else if (etype != ptr_type_now()) begin
				hit = 1'b1;
				r.kind = KIND_BAD_TYPE;
				halted = 1'b1;
			end else begin
				a = ADDR_W'(page_base) + ADDR_W'(off) + slide;
				hit = 1'b1;
				if (a <= last_fixup) begin
					r.kind = KIND_NOT_ASC;
					halted = 1'b1;
				end else begin
					last_fixup = a;
					r.kind = KIND_ADDR;
					r.addr = a;
				end
			end
		end
		endcase
		if (fin && !halted) begin
			halted = 1'b1;
			if (!hit) begin
				hit = 1'b1;
				r.kind = KIND_END;
			end
		end
		if (hit)
			fixups_due.push_back(r);
	endfunction

	task automatic push_word(input logic [WORD_W-1:0] w, input logic fin);
		tbl_word_t t;
		t.word = w;
		t.fin  = fin;
		table_words.push_back(t);
		queued++;
	endtask

	task automatic push_header(input logic [PAGE_W-1:0] page, input logic [31:0] size);
		push_word(page[15:0], 1'b0);
		push_word(page[31:16], 1'b0);
		push_word(size[15:0], 1'b0);
		push_word(size[31:16], 1'b0);
	endtask

	task automatic push_ptr(input logic [PAGE_W-1:0] page, input logic [OFFSET_W-1:0] off,
		input logic fin);
		gen_last = ADDR_W'(page) + ADDR_W'(off) + slide;
		push_word({ptr_type_now(), off}, fin);
	endtask

	// well-formed block: pointers at rising offsets, absolute entries mixed in
	task automatic push_block(input logic [PAGE_W-1:0] page, input int n);
		logic [OFFSET_W:0] off;
		logic [ADDR_W-1:0] a;
		push_header(page, 32'(8 + 2 * n + $urandom_range(0, 1)));
		off = 13'($urandom_range(0, 15));
		for (int i = 0; i < n; i++) begin
			a = ADDR_W'(page) + ADDR_W'(off) + slide;
			if ($urandom_range(0, 3) == 0 || off > 13'hfff || a <= gen_last) begin
				push_word({TYPE_ABS, 12'($urandom)}, 1'b0);
			end else begin
				push_ptr(page, off[OFFSET_W-1:0], 1'b0);
				off = off + 13'($urandom_range(1, 300));
			end
		end
	endtask

	task automatic fill_blocks(input int unsigned step_max, input int budget);
		int stop_at;
		stop_at = queued + budget;
		while (queued < stop_at) begin
			page_cur = page_cur + PAGE_W'($urandom_range(32'h1000, step_max));
			push_block(page_cur, ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 12)));
		end
	endtask

	task automatic settle();
		do @(posedge clk);
		while (words_taken != queued || fixups_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_LOAD_SLIDE)
			slide = val;
		else
			ptr64 = val[0];
	endtask

	task automatic set_mode(input logic [ADDR_W-1:0] slide_v, input logic ptr_v);
		settle();
		write_reg(REG_LOAD_SLIDE, slide_v);
		write_reg(REG_PTR64, CFG_DATA_W'(ptr_v));
	endtask

	// word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words.valid      <= 1'b0;
			words.table_word <= '0;
			words.final_word <= 1'b0;
			tx_gap           <= 0;
		end else begin
			if (words.valid && words.ready) begin
				parse_word(words.table_word, words.final_word);
				words_taken <= words_taken + 1;
			end
			if (!words.valid || words.ready) begin
				if (tx_gap != 0) begin
					words.valid <= 1'b0;
					tx_gap      <= tx_gap - 1;
				end else if (table_words.size() != 0) begin
					tx_next = table_words.pop_front();
					words.valid      <= 1'b1;
					words.table_word <= tx_next.word;
					words.final_word <= tx_next.fin;
					// keep offering back to back while the receiver is on a long hold or a send burst is on
					tx_gap <= (rx_hold != 0 || tx_burst) ? 0 : $urandom_range(0, 13);
					if ($urandom_range(0, 59) == 0)
						tx_burst <= !tx_burst;
				end else begin
					words.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and ready driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			rx_gap        <= 0;
			rx_hold       <= 0;
		end else begin
			if (results.valid && results.ready) begin
				rx_taken <= rx_taken + 1;
				if (fixups_due.size() == 0) begin
					$display("%0t: unexpected result: kind %0d address %h", $time,
						results.result_kind, results.fixup_address);
					mismatches++;
				end else begin
					rx_want = fixups_due.pop_front();
					if (results.result_kind !== rx_want.kind ||
						results.fixup_address !== rx_want.addr) begin
						$display("%0t: expected kind %0d address %h, got kind %0d address %h",
							$time, rx_want.kind, rx_want.addr, results.result_kind,
							results.fixup_address);
						mismatches++;
					end
				end
			end
			if (rx_hold != 0) begin
				results.ready <= 1'b0;
				rx_hold       <= rx_hold - 1;
			end else if (results.valid && results.ready) begin
				if (rx_taken == 30 || rx_taken == 500) begin
					results.ready <= 1'b0;
					rx_hold       <= LONG_HOLD;
				end else begin
					rx_draw = rx_burst ? 0 : $urandom_range(0, 13);
					results.ready <= (rx_draw == 0);
					rx_gap        <= (rx_draw == 0) ? 0 : rx_draw - 1;
					if ($urandom_range(0, 39) == 0)
						rx_burst <= !rx_burst;
				end
			end else if (rx_gap != 0) begin
				results.ready <= 1'b0;
				rx_gap        <= rx_gap - 1;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((words.valid && words.ready) || (results.valid && results.ready)) begin
			stall_cycles <= 0;
		end else if (arst_n) begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("base_relocation_table_parser: mismatch");
				$finish;
			end
		end
	end

	initial begin
		stop_t             stop;
		logic [TYPE_W-1:0] bad;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// max slide: every address wraps to one below page + offset
		set_mode('1, 1'b1);
		push_header(32'h0000_1000, 32'd9);
		push_header(32'h0000_2000, 32'd17);
		push_ptr(32'h0000_2000, 12'h000, 1'b0);
		push_word({TYPE_ABS, 12'hfff}, 1'b0);
		push_ptr(32'h0000_2000, 12'hfff, 1'b0);
		push_word({TYPE_ABS, 12'h000}, 1'b0);
		page_cur = 32'h0000_2000;
		fill_blocks(32'h4000, PHASE_WORDS);

		set_mode('0, 1'b0);
		fill_blocks(32'h4000, PHASE_WORDS);

		set_mode(({$urandom, $urandom} & 64'h3fff_ffff_ffff_ffff) | 64'h4_0000_0000, 1'b1);
		page_cur = '0;
		fill_blocks(32'h0100_0000, PHASE_WORDS);

		// top of the address space; the last page is the highest one
		set_mode(64'hffff_fffe_0000_0000, 1'b0);
		page_cur = '0;
		fill_blocks(32'h0100_0000, PHASE_WORDS);

		stop = stop_t'($urandom_range(0, 4));
		page_cur = 32'hffff_f000;
		case (stop)
		STOP_ZERO_SIZE: push_header(page_cur, 32'($urandom_range(0, 1)));
		STOP_SHORT:     push_header(page_cur, 32'($urandom_range(2, 7)));
		default: begin
			// oversized block, so the table ends inside its entries
			push_header(page_cur, {16'($urandom_range(1, 16'hffff)), 16'($urandom)});
			push_ptr(page_cur, 12'h000, 1'b0);
			push_ptr(page_cur, 12'h800, 1'b0);
			case (stop)
			STOP_BAD_TYPE: begin
				do bad = TYPE_W'($urandom_range(1, 15));
				while (bad == ptr_type_now());
				push_word({bad, 12'($urandom)}, 1'b0);
			end
			STOP_ORDER: push_word({ptr_type_now(), 12'($urandom_range(0, 12'h800))}, 1'b0);
			default: begin
				if ($urandom_range(0, 1))
					push_ptr(page_cur, 12'hfff, 1'b1);
				else
					push_word({TYPE_ABS, 12'($urandom)}, 1'b1);
			end
			endcase
		end
		endcase
		// the parser is halted now: these words must give nothing
		for (int i = 0; i < 16; i++)
			push_word(16'($urandom), (i == 15) || ($urandom_range(0, 3) == 0));

		settle();
		$display("%0d table words sent, %0d result items checked", queued, rx_taken);
		$display("four slide/pointer-type settings; table ended by %s", stop.name());
		if (mismatches == 0)
			$display("base_relocation_table_parser: match");
		else
			$display("base_relocation_table_parser: mismatch");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/brtp_pkg.sv
rtl/core/brtp_ifs.sv
rtl/core/brtp_front.sv
rtl/core/brtp_fifo.sv
rtl/core/brtp_back.sv
rtl/core/base_relocation_table_parser.sv
verif/tb_base_relocation_table_parser.sv
